// ===== rtl/core/symmetry_matrix_table_engine_macros.svh =====
// Assertion macros shared by the checker of the symmetry matrix table engine.
`ifndef SYMMETRY_MATRIX_TABLE_ENGINE_MACROS_SVH
`define SYMMETRY_MATRIX_TABLE_ENGINE_MACROS_SVH

// Implication within the same cycle, disabled during reset.
`define SMTE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle, disabled during reset.
`define SMTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/smte_pkg.sv =====
// Types, codes and helpers shared by the symmetry matrix table engine.
package smte_pkg;

	localparam int unsigned MAX_OPS_DEF = 64;
	localparam int unsigned NELEM = 9;

	typedef logic signed [3:0] elem_t;
	// Row-major: element r*3+c sits at position r*3+c.
	typedef elem_t [0:NELEM-1] mat_t;

	localparam mat_t UNIT_MAT = '{
		4'sd1, 4'sd0, 4'sd0,
		4'sd0, 4'sd1, 4'sd0,
		4'sd0, 4'sd0, 4'sd1
	};

	typedef enum logic [2:0] {
		OP_APPEND  = 3'd0,
		OP_WRITE   = 3'd1,
		OP_READ    = 3'd2,
		OP_FIND    = 3'd3,
		OP_INVERSE = 3'd4,
		OP_CLEAR   = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0] operation;
		logic [5:0] index;
		elem_t      elem_00;
		elem_t      elem_01;
		elem_t      elem_02;
		elem_t      elem_10;
		elem_t      elem_11;
		elem_t      elem_12;
		elem_t      elem_20;
		elem_t      elem_21;
		elem_t      elem_22;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic [6:0] result_index;
		elem_t      out_00;
		elem_t      out_01;
		elem_t      out_02;
		elem_t      out_10;
		elem_t      out_11;
		elem_t      out_12;
		elem_t      out_20;
		elem_t      out_21;
		elem_t      out_22;
	} rsp_t;

	function automatic mat_t req_mat(req_t r);
		mat_t m;
		m[0] = r.elem_00;
		m[1] = r.elem_01;
		m[2] = r.elem_02;
		m[3] = r.elem_10;
		m[4] = r.elem_11;
		m[5] = r.elem_12;
		m[6] = r.elem_20;
		m[7] = r.elem_21;
		m[8] = r.elem_22;
		return m;
	endfunction

	function automatic rsp_t make_rsp(status_t st, logic [6:0] ri, mat_t m);
		rsp_t r;
		r.status       = st;
		r.result_index = ri;
		r.out_00       = m[0];
		r.out_01       = m[1];
		r.out_02       = m[2];
		r.out_10       = m[3];
		r.out_11       = m[4];
		r.out_12       = m[5];
		r.out_20       = m[6];
		r.out_21       = m[7];
		r.out_22       = m[8];
		return r;
	endfunction

endpackage

// ===== rtl/core/smte_store.sv =====
// Matrix table memory: one write port, one read port with registered data.
module smte_store #(
	parameter int unsigned DEPTH = smte_pkg::MAX_OPS_DEF,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  smte_pkg::mat_t  wdata,
	input  logic [AW-1:0]   raddr,
	output smte_pkg::mat_t  rdata
);

	smte_pkg::mat_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/smte_match.sv =====
// Compare unit: exact equality, or test that cand * opnd is the identity.
module smte_match (
	input  logic           inv_mode,
	input  smte_pkg::mat_t cand,
	input  smte_pkg::mat_t opnd,
	output logic           hit
);

	logic prod_ok;

	always_comb begin
		logic signed [9:0] acc;
		prod_ok = 1'b1;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				acc = '0;
				for (int k = 0; k < 3; k++) begin
					acc = acc + cand[r*3+k] * opnd[k*3+c];
				end
				if (acc != smte_pkg::UNIT_MAT[r*3+c]) begin
					prod_ok = 1'b0;
				end
			end
		end
	end

	assign hit = inv_mode ? prod_ok : (cand == opnd);

endmodule

// ===== rtl/core/symmetry_matrix_table_engine.sv =====
// Top level of the symmetry matrix table engine: sequencer, count and table.
//
// Use: drive req and raise start; a request is taken at a rising edge with
// start high and busy low. Exactly one response follows per request: rsp is
// valid for the single cycle in which done is high, and must be taken then,
// as the receiver has no way to hold it off.
// Steps from the accepting edge to the cycle with done high:
//   append, write, clear, unused codes, and any out-of-range request: done
//   straight from idle. read in range: one memory read (S_READ).
//   find: scan from entry zero (S_SCAN) until a match or the last entry.
//   inverse: fetch the indexed entry (S_FETCH), then scan as find does.
// Throughput: busy is low again in the cycle that shows done, so the next
// request may be taken there. Find and inverse are bound by the single read
// port of the table, which delivers one stored matrix per cycle to the
// compare unit, so a request may scan a full table of 64 entry by entry.
// Reset clears the entry count and the sequencer; the table itself keeps
// no reset value, and only entries below the count are ever looked at.
// Out_xx fields are zero in every response except a successful read.
module symmetry_matrix_table_engine #(
	parameter int unsigned MAX_OPS = smte_pkg::MAX_OPS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  smte_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output smte_pkg::rsp_t rsp
);

	// Address, count, index-compare and result widths.
	localparam int unsigned AW = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
	localparam int unsigned CW = $clog2(MAX_OPS + 1);
	localparam int unsigned IW = (CW > 6) ? CW : 6;
	localparam int unsigned XW = (CW > 7) ? CW : 7;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_FETCH,
		S_SCAN
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   j_q;
	logic [5:0]      idx_q;
	logic            inv_q;
	smte_pkg::mat_t  opnd_q;
	smte_pkg::rsp_t  rsp_q;
	logic            done_q;

	logic            accept;
	logic [IW-1:0]   idx_x;
	logic [AW-1:0]   idx_a;
	logic            in_range;
	logic            full;
	logic [CW-1:0]   count_inc;
	logic [XW-1:0]   count_x;
	logic [XW-1:0]   count_inc_x;
	logic            last;
	logic            hit;

	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [AW-1:0]   mem_raddr;
	smte_pkg::mat_t  mem_rdata;

	assign accept      = start && (state_q == S_IDLE);
	assign idx_x       = IW'(req.index);
	assign idx_a       = idx_x[AW-1:0];
	assign in_range    = idx_x < IW'(count_q);
	assign full        = (count_q == CW'(MAX_OPS));
	assign count_inc   = count_q + CW'(1);
	assign count_x     = XW'(count_q);
	assign count_inc_x = XW'(count_inc);
	// The entry under test is the last one below the count.
	assign last        = ((CW'(j_q) + CW'(1)) == count_q);

	// Memory control: writes only on an accepted append or in-range write;
	// reads go ahead every cycle and the sequencer picks what it needs.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (req.operation == smte_pkg::OP_APPEND) && !full) begin
					mem_we = 1'b1;
				end
				if (accept && (req.operation == smte_pkg::OP_WRITE) && in_range) begin
					mem_we    = 1'b1;
					mem_waddr = idx_a;
				end
				// Find starts its scan at entry zero; read and inverse fetch
				// the indexed entry first.
				if (req.operation != smte_pkg::OP_FIND) begin
					mem_raddr = idx_a;
				end
			end
			S_SCAN: begin
				mem_raddr = j_q + AW'(1);
			end
			S_READ, S_FETCH: begin
				mem_raddr = '0;
			end
		endcase
	end

	smte_store #(
		.DEPTH (MAX_OPS),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (smte_pkg::req_mat(req)),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	smte_match u_match (
		.inv_mode (inv_q),
		.cand     (mem_rdata),
		.opnd     (opnd_q),
		.hit      (hit)
	);

	// Sequencer, entry count and the registered response.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			j_q     <= '0;
			idx_q   <= '0;
			inv_q   <= 1'b0;
			opnd_q  <= '0;
			rsp_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			// The strobe lasts one cycle unless set again below.
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= req.index;
						j_q   <= '0;
						unique case (req.operation)
							smte_pkg::OP_APPEND: begin
								done_q <= 1'b1;
								if (full) begin
									rsp_q <= smte_pkg::make_rsp(smte_pkg::ST_FULL,
										count_x[6:0], '0);
								end else begin
									count_q <= count_inc;
									rsp_q   <= smte_pkg::make_rsp(smte_pkg::ST_OK,
										count_inc_x[6:0], '0);
								end
							end
							smte_pkg::OP_WRITE: begin
								done_q <= 1'b1;
								rsp_q  <= smte_pkg::make_rsp(
									in_range ? smte_pkg::ST_OK : smte_pkg::ST_RANGE,
									7'(req.index), '0);
							end
							smte_pkg::OP_READ: begin
								if (in_range) begin
									state_q <= S_READ;
								end else begin
									done_q <= 1'b1;
									rsp_q  <= smte_pkg::make_rsp(smte_pkg::ST_RANGE,
										7'(req.index), '0);
								end
							end
							smte_pkg::OP_FIND: begin
								inv_q  <= 1'b0;
								opnd_q <= smte_pkg::req_mat(req);
								if (count_q == '0) begin
									done_q <= 1'b1;
									rsp_q  <= smte_pkg::make_rsp(smte_pkg::ST_NOT_FOUND,
										count_x[6:0], '0);
								end else begin
									state_q <= S_SCAN;
								end
							end
							smte_pkg::OP_INVERSE: begin
								inv_q <= 1'b1;
								if (in_range) begin
									state_q <= S_FETCH;
								end else begin
									done_q <= 1'b1;
									rsp_q  <= smte_pkg::make_rsp(smte_pkg::ST_RANGE,
										7'(req.index), '0);
								end
							end
							smte_pkg::OP_CLEAR: begin
								count_q <= '0;
								done_q  <= 1'b1;
								rsp_q   <= smte_pkg::make_rsp(smte_pkg::ST_OK, '0, '0);
							end
							default: begin
								done_q <= 1'b1;
								rsp_q  <= smte_pkg::make_rsp(smte_pkg::ST_OK,
									count_x[6:0], '0);
							end
						endcase
					end
				end
				S_READ: begin
					// Read data for the requested entry arrives now.
					done_q  <= 1'b1;
					rsp_q   <= smte_pkg::make_rsp(smte_pkg::ST_OK, 7'(idx_q), mem_rdata);
					state_q <= S_IDLE;
				end
				S_FETCH: begin
					// Hold R_i as the right-hand operand; entry zero is on its way.
					opnd_q  <= mem_rdata;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (hit) begin
						done_q  <= 1'b1;
						rsp_q   <= smte_pkg::make_rsp(smte_pkg::ST_OK, 7'(j_q), '0);
						state_q <= S_IDLE;
					end else if (last) begin
						done_q  <= 1'b1;
						rsp_q   <= smte_pkg::make_rsp(smte_pkg::ST_NOT_FOUND,
							count_x[6:0], '0);
						state_q <= S_IDLE;
					end else begin
						j_q <= j_q + AW'(1);
					end
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== rtl/core/smte_checker.sv =====
// Port-level checker for the symmetry matrix table engine, bound to the top.
`include "symmetry_matrix_table_engine_macros.svh"

module smte_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input smte_pkg::req_t req,
	input smte_pkg::rsp_t rsp
);

	logic quick_req;
	logic outs_zero;

	// Requests answered straight away without touching the read port:
	// everything but read, find and inverse.
	assign quick_req = start && !busy &&
		(req.operation != smte_pkg::OP_READ) && (req.operation != smte_pkg::OP_FIND) &&
		(req.operation != smte_pkg::OP_INVERSE);

	assign outs_zero = (rsp.out_00 == 4'sd0) && (rsp.out_01 == 4'sd0) &&
		(rsp.out_02 == 4'sd0) && (rsp.out_10 == 4'sd0) && (rsp.out_11 == 4'sd0) &&
		(rsp.out_12 == 4'sd0) && (rsp.out_20 == 4'sd0) && (rsp.out_21 == 4'sd0) &&
		(rsp.out_22 == 4'sd0);

	`SMTE_ASSERT_NEXT(a_quick_done, clk, arst_n, quick_req, done, "quick request gave no response")

	`SMTE_ASSERT_NEXT(a_quick_idle, clk, arst_n, quick_req, !busy, "quick request left busy set")

	`SMTE_ASSERT_NOW(a_outs_zero, clk, arst_n, done && (rsp.status != smte_pkg::ST_OK), outs_zero, "failed response carries matrix data")

	`SMTE_ASSERT_NOW(a_busy_cause, clk, arst_n, $rose(busy), $past(start), "busy rose without a request")

endmodule

bind symmetry_matrix_table_engine smte_checker u_smte_checker (.*);
